// File: hw/rtl/sm4_block_cipher_ecb_cbc_core_macros.svh
// Assertion macros used by the SM4 core checker.
// Needs no other file; include it by bare name where assertions are written.
`ifndef SM4_BLOCK_CIPHER_ECB_CBC_CORE_MACROS_SVH
`define SM4_BLOCK_CIPHER_ECB_CBC_CORE_MACROS_SVH

// Check that a condition at one edge implies a consequence at the next edge.
`define SM4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("SM4 core: next-cycle check failed");

// Check that a condition implies a consequence at the same edge.
`define SM4_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("SM4 core: same-cycle check failed");

`endif

// File: hw/rtl/sm4_pkg.sv
// Types, constants and table functions of the SM4 ECB/CBC core.
// Standalone package; sm4_if, the core, sm4_round, sm4_chk and the testbench import it.
`default_nettype none

package sm4_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned BlockW  = 128;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_HIGH = 3'd0,
    CFG_KEY_LOW  = 3'd1,
    CFG_IV_HIGH  = 3'd2,
    CFG_IV_LOW   = 3'd3,
    CFG_DECRYPT  = 3'd4,
    CFG_CBC      = 3'd5
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_KEY_LOAD,
    ST_KEY_EXP,
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } sm4_state_e;

  // Control decoded from the sequencer state
  typedef struct packed {
    logic in_ready;
    logic key_load;
    logic key_step;
    logic blk_load;
    logic round_step;
    logic finish;
  } sm4_ctl_t;

  localparam logic [WordW-1:0] FK0 = 32'ha3b1bac6;
  localparam logic [WordW-1:0] FK1 = 32'h56aa3350;
  localparam logic [WordW-1:0] FK2 = 32'h677d9197;
  localparam logic [WordW-1:0] FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Byte-wise S-box substitution of one word
  function automatic logic [WordW-1:0] tau(input logic [WordW-1:0] a);
    logic [WordW-1:0] r;
    for (int j = 0; j < 4; j++) begin
      r[8*j +: 8] = SBOX[a[8*j +: 8]];
    end
    return r;
  endfunction

  // CK word i: byte j is (4*i + j) * 7 mod 256, byte 0 most significant
  function automatic logic [WordW-1:0] ck_word(input logic [4:0] i);
    logic [WordW-1:0] w;
    logic [7:0]       base;
    base = {1'b0, i, 2'b00};
    for (int j = 0; j < 4; j++) begin
      w[WordW-1-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sm4_if.sv
// Valid/ready channel interfaces of the SM4 core: input block and result.
// Depends on sm4_pkg for field widths.
`default_nettype none

interface sm4_in_if;
  import sm4_pkg::*;
  logic              valid;
  logic              ready;
  logic [HalfW-1:0]  block_high;
  logic [HalfW-1:0]  block_low;
  logic              last_block;

  modport source (output valid, block_high, block_low, last_block, input ready);
  modport sink   (input valid, block_high, block_low, last_block, output ready);
endinterface

interface sm4_out_if;
  import sm4_pkg::*;
  logic              valid;
  logic              ready;
  logic [HalfW-1:0]  out_high;
  logic [HalfW-1:0]  out_low;
  logic              out_last;

  modport source (output valid, out_high, out_low, out_last, input ready);
  modport sink   (input valid, out_high, out_low, out_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sm4_block_cipher_ecb_cbc_core.sv
// Top level of the SM4 ECB/CBC block cipher core.
// Depends on sm4_pkg, sm4_if, sm4_ram and sm4_round.
//
//   channel      dir  handshake            payload
//   in_chan_i    in   valid/ready          block_high, block_low, last_block
//   out_chan_o   out  valid/ready          out_high, out_low, out_last
//   cfg_*_i      in   cfg_we_i (no wait)   cfg_idx_i, cfg_wdata_i
//
// A block is accepted in ST_IDLE, runs its rounds in ST_ROUND and is written to the
// output register from ST_DONE; the sequencer then returns to ST_IDLE for the next
// block. One round a cycle in the shared round unit.
// After reset and after every key write the round keys are expanded into the key RAM
// (ST_KEY_LOAD, then ST_KEY_EXP), with in_chan_i.ready low throughout.
// A new block is accepted while a finished result still waits in the output
// register; the block stalls in its final state until that register frees up.
`default_nettype none

module sm4_block_cipher_ecb_cbc_core
  import sm4_pkg::*;
#(
  parameter int unsigned ROUNDS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  sm4_in_if.sink                  in_chan_i,
  sm4_out_if.source               out_chan_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [HalfW-1:0]   cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(ROUNDS);
  localparam logic [CntW-1:0] LastCnt = CntW'(ROUNDS - 1);

  // Configuration registers
  logic [HalfW-1:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic             decrypt_q, cbc_q;

  // Sequencer
  sm4_state_e       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  sm4_ctl_t         ctl;
  logic             key_wr;
  logic             out_free;
  logic             cnt_last;

  // Datapath
  logic [BlockW-1:0] x_q;
  logic [BlockW-1:0] blk_q;
  logic              last_q;
  logic [BlockW-1:0] chain_q;
  logic              in_msg_q;
  logic [BlockW-1:0] chain_eff;
  logic [BlockW-1:0] in_blk;
  logic [BlockW-1:0] res;
  logic [BlockW-1:0] out_res;
  logic              out_valid_q;
  logic [HalfW-1:0]  out_high_q, out_low_q;
  logic              out_last_q;

  // Round unit and key RAM
  logic [WordW-1:0]  rk;
  logic [WordW-1:0]  rnd_word;
  logic [WordW-1:0]  rk_rdata;
  logic [CntW-1:0]   rk_raddr;
  logic [CntW-1:0]   cnt_nxt;

  assign key_wr   = cfg_we_i && (cfg_idx_i == CFG_KEY_HIGH || cfg_idx_i == CFG_KEY_LOW);
  assign out_free = !out_valid_q || out_chan_o.ready;
  assign cnt_last = (cnt_q == LastCnt);

  // Next state; a key write restarts the key schedule from any state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_KEY_LOAD: state_d = ST_KEY_EXP;
      ST_KEY_EXP:  if (cnt_last) state_d = ST_IDLE;
      ST_IDLE:     if (in_chan_i.valid) state_d = ST_ROUND;
      ST_ROUND:    if (cnt_last) state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_KEY_LOAD;
    endcase
    if (key_wr) begin
      state_d = ST_KEY_LOAD;
    end
  end

  // Control outputs of the sequencer
  always_comb begin
    ctl = '0;
    unique case (state_q)
      ST_KEY_LOAD: ctl.key_load = 1'b1;
      ST_KEY_EXP:  ctl.key_step = 1'b1;
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.blk_load = in_chan_i.valid;
      end
      ST_ROUND:    ctl.round_step = 1'b1;
      ST_DONE:     ctl.finish = out_free;
      default:     ctl = '0;
    endcase
  end

  assign in_chan_i.ready = ctl.in_ready;

  // Round counter: clear on key load and on block accept, advance per key step and per round
  always_comb begin
    cnt_d = cnt_q;
    if (ctl.key_load || ctl.blk_load) begin
      cnt_d = '0;
    end else if (ctl.key_step || ctl.round_step) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_KEY_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      iv_high_q  <= '0;
      iv_low_q   <= '0;
      decrypt_q  <= 1'b0;
      cbc_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        CFG_IV_HIGH:  iv_high_q  <= cfg_wdata_i;
        CFG_IV_LOW:   iv_low_q   <= cfg_wdata_i;
        CFG_DECRYPT:  decrypt_q  <= cfg_wdata_i[0];
        CFG_CBC:      cbc_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Key RAM read address: first key while idle, the next round's key while
  // rounds run, so the registered read lines up with the round that needs it
  assign cnt_nxt = cnt_q + 1'b1;
  always_comb begin
    if (state_q == ST_ROUND) begin
      rk_raddr = decrypt_q ? (LastCnt - cnt_nxt) : cnt_nxt;
    end else begin
      rk_raddr = decrypt_q ? LastCnt : '0;
    end
  end

  sm4_ram #(
    .Width (WordW),
    .Depth (ROUNDS)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.key_step),
    .waddr_i (cnt_q),
    .wdata_i (rnd_word),
    .raddr_i (rk_raddr),
    .rdata_o (rk_rdata)
  );

  // Key schedule feeds CK into the round unit; the cipher feeds the round key
  assign rk = ctl.key_step ? ck_word(5'(cnt_q)) : rk_rdata;

  sm4_round u_round (
    .state_i     (x_q),
    .rk_i        (rk),
    .key_sched_i (ctl.key_step),
    .word_o      (rnd_word)
  );

  // Chain value seen by a new block: IV at a message start
  assign chain_eff = in_msg_q ? chain_q : {iv_high_q, iv_low_q};
  assign in_blk    = {in_chan_i.block_high, in_chan_i.block_low};
  // Final word order is reversed
  assign res       = {x_q[31:0], x_q[63:32], x_q[95:64], x_q[127:96]};
  assign out_res   = (decrypt_q && cbc_q) ? (res ^ chain_q) : res;

  // Working state: key words during expansion, block words during rounds
  always_ff @(posedge clk_i) begin
    if (ctl.key_load) begin
      x_q <= {key_high_q ^ {FK0, FK1}, key_low_q ^ {FK2, FK3}};
    end else if (ctl.blk_load) begin
      x_q    <= (!decrypt_q && cbc_q) ? (in_blk ^ chain_eff) : in_blk;
      blk_q  <= in_blk;
      last_q <= in_chan_i.last_block;
    end else if (ctl.key_step || ctl.round_step) begin
      x_q <= {x_q[95:0], rnd_word};
    end
  end

  // Chain and message tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q  <= '0;
      in_msg_q <= 1'b0;
    end else if (ctl.blk_load) begin
      chain_q  <= chain_eff;
      in_msg_q <= !in_chan_i.last_block;
    end else if (ctl.finish) begin
      chain_q <= decrypt_q ? blk_q : res;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.finish) begin
      out_high_q <= out_res[127:64];
      out_low_q  <= out_res[63:0];
      out_last_q <= last_q;
    end
  end

  assign out_chan_o.valid    = out_valid_q;
  assign out_chan_o.out_high = out_high_q;
  assign out_chan_o.out_low  = out_low_q;
  assign out_chan_o.out_last = out_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/sm4_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sm4_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sm4_round.sv
// Shared SM4 round function: S-box layer plus the data or key-schedule
// linear transform. Depends on sm4_pkg.
`default_nettype none

module sm4_round
  import sm4_pkg::*;
(
  input  wire logic [BlockW-1:0] state_i,
  input  wire logic [WordW-1:0]  rk_i,
  input  wire logic              key_sched_i,
  output      logic [WordW-1:0]  word_o
);

  logic [WordW-1:0] mix;
  logic [WordW-1:0] sub;
  logic [WordW-1:0] lin;

  always_comb begin
    mix = state_i[95:64] ^ state_i[63:32] ^ state_i[31:0] ^ rk_i;
    sub = tau(mix);
    if (key_sched_i) begin
      lin = sub ^ {sub[18:0], sub[31:19]} ^ {sub[8:0], sub[31:9]};
    end else begin
      lin = sub ^ {sub[29:0], sub[31:30]} ^ {sub[21:0], sub[31:22]}
                ^ {sub[13:0], sub[31:14]} ^ {sub[7:0], sub[31:8]};
    end
    word_o = state_i[127:96] ^ lin;
  end

endmodule

`default_nettype wire

// File: hw/rtl/sm4_chk.sv
// Port-level checker of the SM4 ECB/CBC core, bound to the top level.
// Depends on sm4_pkg and sm4_block_cipher_ecb_cbc_core_macros.svh.
`default_nettype none
`include "sm4_block_cipher_ecb_cbc_core_macros.svh"

module sm4_chk
  import sm4_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [HalfW-1:0]   out_high_i,
  input wire logic [HalfW-1:0]   out_low_i,
  input wire logic               out_last_i,
  input wire logic               cfg_we_i,
  input wire logic [CfgIdxW-1:0] cfg_idx_i
);

  logic               key_wr;
  logic               out_stall;
  logic [2*HalfW:0]   out_pay;

  assign key_wr    = cfg_we_i && (cfg_idx_i == CFG_KEY_HIGH || cfg_idx_i == CFG_KEY_LOW);
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_pay   = {out_high_i, out_low_i, out_last_i};

  // The core works one block at a time: busy right after an accept
  `SM4_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A key write restarts the key schedule, which blocks input
  `SM4_ASSERT_NEXT(a_busy_after_key_wr, clk_i, rst_ni, key_wr, !in_ready_i)

  // Hold a stalled result
  `SM4_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_stall, out_valid_i)
  `SM4_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_stall, $stable(out_pay))

endmodule

bind sm4_block_cipher_ecb_cbc_core sm4_chk u_sm4_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan_i.valid),
  .in_ready_i  (in_chan_i.ready),
  .out_valid_i (out_chan_o.valid),
  .out_ready_i (out_chan_o.ready),
  .out_high_i  (out_chan_o.out_high),
  .out_low_i   (out_chan_o.out_low),
  .out_last_i  (out_chan_o.out_last),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i)
);

`default_nettype wire

// File: tb/sv/sm4_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the SM4 ECB/CBC core: tracks register writes, predicts each block.
// Needs sm4_pkg for widths and register indexes, and sm4_if for the two channels.
module sm4_result_checker
  import sm4_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  sm4_in_if                  in_mon_i,
  sm4_out_if                 out_mon_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [HalfW-1:0]   cfg_wdata_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  localparam int unsigned NumRounds  = 32;
  localparam int unsigned MaxReports = 10;

  localparam logic [WordW-1:0] KeyMask0 = 32'ha3b1bac6;
  localparam logic [WordW-1:0] KeyMask1 = 32'h56aa3350;
  localparam logic [WordW-1:0] KeyMask2 = 32'h677d9197;
  localparam logic [WordW-1:0] KeyMask3 = 32'hb27022dc;

  // Substitution table, entry 0 in the most significant byte
  localparam logic [0:255][7:0] SubTable = {
    64'hd690e9fecce13db7, 64'h16b614c228fb2c05, 64'h2b679a762abe04c3, 64'haa44132649860699,
    64'h9c4250f491ef987a, 64'h33540b43edcfac62, 64'he4b31ca9c908e895, 64'h80df94fa758f3fa6,
    64'h4707a7fcf37317ba, 64'h83593c19e6854fa8, 64'h686b81b27164da8b, 64'hf8eb0f4b70569d35,
    64'h1e240e5e6358d1a2, 64'h25227c3b01217887, 64'hd40046579fd32752, 64'h4c3602e7a0c4c89e,
    64'heabf8ad240c738b5, 64'ha3f7f2cef96115a1, 64'he0ae5da49b341a55, 64'had933230f58cb1e3,
    64'h1df6e22e8266ca60, 64'hc02923ab0d534e6f, 64'hd5db3745defd8e2f, 64'h03ff6a726d6c5b51,
    64'h8d1baf92bbddbc7f, 64'h11d95c411f105ad8, 64'h0ac13188a5cd7bbd, 64'h2d74d012b8e5b4b0,
    64'h8969974a0c96777e, 64'h65b9f109c56ec684, 64'h18f07dec3adc4d20, 64'h79ee5f3ed7cb3948
  };

  typedef struct packed {
    logic [HalfW-1:0] high;
    logic [HalfW-1:0] low;
    logic             last;
  } cipher_result_t;

  logic [HalfW-1:0]  key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic              decrypt_q, cbc_q;
  logic [WordW-1:0]  sched_word [NumRounds];
  logic [BlockW-1:0] chain_q;
  logic              in_message_q;
  cipher_result_t    predicted_blocks [$];
  int                failures;

  function automatic logic [WordW-1:0] sub_word(input logic [WordW-1:0] a);
    return {SubTable[a[31:24]], SubTable[a[23:16]], SubTable[a[15:8]], SubTable[a[7:0]]};
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int unsigned n);
    return (x << n) | (x >> (WordW - n));
  endfunction

  task automatic expand_round_keys();
    logic [WordW-1:0] k [4];
    logic [WordW-1:0] ck, t, nk;
    k[0] = key_high_q[63:32] ^ KeyMask0;
    k[1] = key_high_q[31:0]  ^ KeyMask1;
    k[2] = key_low_q[63:32]  ^ KeyMask2;
    k[3] = key_low_q[31:0]   ^ KeyMask3;
    for (int i = 0; i < NumRounds; i++) begin
      ck = '0;
      for (int j = 0; j < 4; j++) begin
        ck = {ck[23:0], 8'((4 * i + j) * 7)};
      end
      t  = sub_word(k[1] ^ k[2] ^ k[3] ^ ck);
      nk = k[0] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
      sched_word[i] = nk;
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
    end
  endtask

  // Run the 32 rounds; reverse the key order to decrypt
  function automatic logic [BlockW-1:0] run_rounds(input logic [BlockW-1:0] blk,
                                                    input logic reverse);
    logic [WordW-1:0] x [4];
    logic [WordW-1:0] rk, b, nx;
    x[0] = blk[127:96]; x[1] = blk[95:64]; x[2] = blk[63:32]; x[3] = blk[31:0];
    for (int r = 0; r < NumRounds; r++) begin
      rk = reverse ? sched_word[NumRounds - 1 - r] : sched_word[r];
      b  = sub_word(x[1] ^ x[2] ^ x[3] ^ rk);
      nx = x[0] ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
    end
    return {x[3], x[2], x[1], x[0]};
  endfunction

  // Apply chaining around the rounds and queue the expected result
  task automatic chain_and_cipher(input logic [BlockW-1:0] blk, input logic last);
    logic [BlockW-1:0] res;
    cipher_result_t    exp_blk;
    if (!in_message_q) chain_q = {iv_high_q, iv_low_q};
    if (!decrypt_q) begin
      res     = run_rounds(cbc_q ? blk ^ chain_q : blk, 1'b0);
      chain_q = res;
    end else begin
      res     = run_rounds(blk, 1'b1);
      if (cbc_q) res = res ^ chain_q;
      chain_q = blk;
    end
    in_message_q = !last;
    exp_blk.high = res[127:64];
    exp_blk.low  = res[63:0];
    exp_blk.last = last;
    predicted_blocks.push_back(exp_blk);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    cipher_result_t got, want;
    if (!rst_ni) begin
      key_high_q   = '0;
      key_low_q    = '0;
      iv_high_q    = '0;
      iv_low_q     = '0;
      decrypt_q    = 1'b0;
      cbc_q        = 1'b0;
      chain_q      = '0;
      in_message_q = 1'b0;
      failures     = 0;
      predicted_blocks.delete();
      expand_round_keys();
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.high = out_mon_i.out_high;
        got.low  = out_mon_i.out_low;
        got.last = out_mon_i.out_last;
        if (predicted_blocks.size() == 0) begin
          failures++;
          if (failures <= MaxReports)
            $display("%0t: unexpected result %h %h last %b", $time, got.high, got.low,
                     got.last);
        end else begin
          want = predicted_blocks.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= MaxReports)
              $display("%0t: mismatch: expected %h %h last %b, got %h %h last %b", $time,
                       want.high, want.low, want.last, got.high, got.low, got.last);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_HIGH: begin
            key_high_q = cfg_wdata_i;
            expand_round_keys();
          end
          CFG_KEY_LOW: begin
            key_low_q = cfg_wdata_i;
            expand_round_keys();
          end
          CFG_IV_HIGH: iv_high_q = cfg_wdata_i;
          CFG_IV_LOW:  iv_low_q  = cfg_wdata_i;
          CFG_DECRYPT: decrypt_q = cfg_wdata_i[0];
          CFG_CBC:     cbc_q     = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready)
        chain_and_cipher({in_mon_i.block_high, in_mon_i.block_low}, in_mon_i.last_block);
    end
    pending_o    <= predicted_blocks.size();
    fail_count_o <= failures;
  end

endmodule

// File: tb/sv/sm4_block_cipher_ecb_cbc_core_test.sv
`timescale 1ns / 100ps
// Top of the SM4 ECB/CBC core test: clock, reset, block and register stimulus, verdict.
// Needs sm4_pkg, sm4_if, the core itself and sm4_result_checker.
module sm4_block_cipher_ecb_cbc_core_test;
  import sm4_pkg::*;

  localparam int unsigned RandomItems   = 1150;
  localparam int unsigned MaxGap        = 17;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned IdleLimit     = 3000;
  localparam int unsigned EndCycles     = 40;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 3'd7;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [HalfW-1:0]   cfg_wdata;
  int                 pending;
  int                 fail_count;
  bit                 tx_steady;
  bit                 rx_steady;
  bit                 rx_hold_req;

  sm4_in_if  in_chan ();
  sm4_out_if out_chan ();

  sm4_block_cipher_ecb_cbc_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan_i   (in_chan),
    .out_chan_o  (out_chan),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  sm4_result_checker result_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_chan),
    .out_mon_i    (out_chan),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly random words, with all-zero and all-one values mixed in
  function automatic logic [HalfW-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one block after a random gap and hold it until the transaction completes.
  // Valid stays high straight into the next block when no gap is drawn.
  task automatic send_block(input logic [HalfW-1:0] hi, input logic [HalfW-1:0] lo,
                            input logic last);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_chan.valid      <= 1'b1;
    in_chan.block_high <= hi;
    in_chan.block_low  <= lo;
    in_chan.last_block <= last;
    do @(posedge clk_i); while (!in_chan.ready);
  endtask

  // Drop valid and wait until every predicted result has been taken.
  // The first edge is always waited out so the checker's count includes the last block.
  task automatic settle(input int unsigned extra);
    in_chan.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  // Write one register while the core is idle, then wait until it takes input again;
  // a key write keeps ready low for the whole key expansion.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [HalfW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
  endtask

  // Rewrite a random subset of the registers; favor CBC since it exercises the chain
  task automatic pick_settings();
    logic [HalfW-1:0] mode_word;
    if ($urandom_range(0, 2) == 0) write_reg(CFG_KEY_HIGH, pick_word());
    if ($urandom_range(0, 2) == 0) write_reg(CFG_KEY_LOW, pick_word());
    if ($urandom_range(0, 1) == 0) write_reg(CFG_IV_HIGH, pick_word());
    if ($urandom_range(0, 1) == 0) write_reg(CFG_IV_LOW, pick_word());
    if ($urandom_range(0, 1) == 0) write_reg(CFG_DECRYPT, {$urandom, $urandom});
    if ($urandom_range(0, 1) == 0) begin
      mode_word    = {$urandom, $urandom};
      mode_word[0] = ($urandom_range(0, 3) != 0);
      write_reg(CFG_CBC, mode_word);
    end
    if ($urandom_range(0, 5) == 0) write_reg(CFG_SPARE_A, pick_word());
    if ($urandom_range(0, 5) == 0) write_reg(CFG_SPARE_B, pick_word());
  endtask

  // Receiver: draw a stall per result; honor one long hold-off when requested
  initial begin : receiver
    int unsigned hold;
    out_chan.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold = HoldOffCycles;
      end else begin
        if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
        hold = rx_steady ? 0 : $urandom_range(0, MaxGap);
      end
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk_i); while (!out_chan.valid);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || cfg_we)
        idle = 0;
      else
        idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_len;
    int unsigned msg_left;
    bit          hold_done;
    logic        last;

    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_KEY_HIGH;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.block_high = '0;
    in_chan.block_low  = '0;
    in_chan.last_block = 1'b0;
    tx_steady          = 1'b0;
    rx_steady          = 1'b0;
    rx_hold_req        = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero key, ECB, encrypt. Drive the field extremes.
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);
    send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b1);

    // Standard key and plaintext; only bit 0 of a mode write counts, so stay encrypting
    settle(2);
    write_reg(CFG_KEY_HIGH, 64'h0123_4567_89ab_cdef);
    write_reg(CFG_KEY_LOW, 64'hfedc_ba98_7654_3210);
    write_reg(CFG_IV_HIGH, 64'h0001_0203_0405_0607);
    write_reg(CFG_IV_LOW, 64'h0809_0a0b_0c0d_0e0f);
    write_reg(CFG_DECRYPT, 64'hffff_ffff_ffff_fffe);
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);

    // CBC encrypt: a three-block message, then a second one restarting from the IV
    settle(2);
    write_reg(CFG_CBC, 64'h5555_5555_5555_5555);
    send_block(pick_word(), pick_word(), 1'b0);
    send_block(pick_word(), pick_word(), 1'b0);
    send_block(pick_word(), pick_word(), 1'b1);
    send_block(pick_word(), pick_word(), 1'b0);
    send_block(pick_word(), pick_word(), 1'b1);

    // Open a message, then change the IV mid-message: the chain must carry on
    send_block(pick_word(), pick_word(), 1'b0);
    settle(2);
    write_reg(CFG_IV_HIGH, '1);
    write_reg(CFG_IV_LOW, '1);
    write_reg(CFG_SPARE_A, {$urandom, $urandom});
    write_reg(CFG_SPARE_B, {$urandom, $urandom});
    send_block(pick_word(), pick_word(), 1'b0);

    // Switch to decrypt mid-message; the next message starts from the new IV
    settle(2);
    write_reg(CFG_DECRYPT, 64'h1);
    send_block(pick_word(), pick_word(), 1'b1);
    send_block(pick_word(), pick_word(), 1'b0);

    // New key mid-message
    settle(2);
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_KEY_LOW, '1);
    send_block(pick_word(), pick_word(), 1'b1);

    // ECB still updates the chain; switch back to CBC mid-message to expose it
    settle(2);
    write_reg(CFG_CBC, 64'hffff_ffff_ffff_fffe);
    send_block('0, '0, 1'b0);
    settle(2);
    write_reg(CFG_CBC, 64'h1);
    send_block('1, '1, 1'b1);

    // Random phases: new settings between phases, well-formed messages with random
    // content, some broken boundaries. Phase ends often cut a message in two.
    sent      = 0;
    msg_left  = 0;
    hold_done = 1'b0;
    while (sent < RandomItems) begin
      settle(2);
      pick_settings();
      phase_len = $urandom_range(20, 90);
      // Stall the receiver once at a phase start, so blocks keep coming and back up the core
      if (!hold_done && sent >= RandomItems / 3) begin
        rx_hold_req = 1'b1;
        hold_done   = 1'b1;
      end
      repeat (phase_len) begin
        if (msg_left == 0) msg_left = $urandom_range(1, 8);
        msg_left--;
        last = (msg_left == 0);
        if ($urandom_range(0, 9) == 0) last = $urandom_range(0, 1);
        send_block(pick_word(), pick_word(), last);
        sent++;
      end
    end

    settle(EndCycles);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
